// File: hdl/accel_z_calibrate_reconstruct_assert.svh
// Assertion macros shared by the checker of the accelerometer z block.
// Depends on nothing; each file that asserts includes this header.
`ifndef ACCEL_Z_CALIBRATE_RECONSTRUCT_ASSERT_SVH
`define ACCEL_Z_CALIBRATE_RECONSTRUCT_ASSERT_SVH

// Implication in the same cycle, disabled while reset is high.
`define AZC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication checked in the next cycle, disabled while reset is high.
`define AZC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/azc_pkg.sv
// Shared types, register codes and constant tables of the accelerometer z block.
// Depends on nothing; used by the controller, the datapath and the top level.
package azc_pkg;

   localparam int RawW  = 12;
   localparam int OutW  = 13;
   localparam int RootW = 11;
   localparam int SqrtW = 22;
   localparam int DivW  = 16;
   localparam int SumW  = 17;

   typedef enum logic [1:0] {
      CSR_FULL_SCALE = 2'd0,
      CSR_X_OFFSET   = 2'd1,
      CSR_Y_OFFSET   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_MEAN = 2'd0,
      DIV_SMX  = 2'd1,
      DIV_SMY  = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        cal_fail;
      logic        sq0;
      logic        sq1;
      logic        sq2;
      logic        use_smooth;
      logic        root_go;
      logic        accum;
      logic        div_go;
      logic        div_take;
      div_sel_type div_sel;
      logic        apply;
      logic        held_take;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic cal_done;
      logic pass;
      logic rebuilt;
      logic cal_full;
      logic rad_pos;
      logic root_done;
      logic div_done;
      logic out_free;
   } sts_type;

   // One-g magnitude in counts for each full-scale code.
   function automatic logic [RootW-1:0] one_g(input logic [1:0] sel);
      logic [RootW-1:0] r;
      case (sel)
         2'd0:    r = 11'd1024;
         2'd1:    r = 11'd512;
         2'd2:    r = 11'd256;
         default: r = 11'd128;
      endcase
      return r;
   endfunction

   // Square of the one-g magnitude.
   function automatic logic [20:0] one_g_sq(input logic [1:0] sel);
      logic [20:0] r;
      case (sel)
         2'd0:    r = 21'd1048576;
         2'd1:    r = 21'd262144;
         2'd2:    r = 21'd65536;
         default: r = 21'd16384;
      endcase
      return r;
   endfunction

   function automatic logic [13:0] abs14(input logic signed [13:0] v);
      logic [13:0] a;
      a = v[13] ? 14'(-v) : 14'(v);
      return a;
   endfunction

endpackage

// File: hdl/accel_z_calibrate_reconstruct.sv
// A request is loaded, checked, offset-applied and registered; a passing calibration
// sample adds squaring, root and accumulation steps, the completing one the mean division;
// a z rebuild adds two smoothing divisions, squaring and the root (skipped when the last
// good z is held because the root would be invalid). One request at a time, taken the
// cycle after the previous result is loaded; the 11-step root unit sets the longest paths.
// Reset (synchronous, active high) clears configuration, calibration and smoothing state.
module accel_z_calibrate_reconstruct
   import azc_pkg::*;
#(
   parameter int CAL_SAMPLES = 10,
   parameter int Z_LIMIT     = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // x_word[15:0], y_word[31:16], z_word[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // x_out[12:0], y_out[25:13], z_out[38:26], zero pad
   output logic [1:0]  rsp_tuser,   // z_rebuilt[0], is_calibrated[1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // Configuration is always taken; the user must write it only while the block is idle (unenforced).
   assign csr_ready = 1'b1;

   // The controller walks each request, as it needs, through the level test, the squaring steps,
   // the root and divider units and finally the output register.
   azc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the configuration, the calibration record and all arithmetic.
   azc_dp #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .Z_LIMIT     (Z_LIMIT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: hdl/azc_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on nothing; instantiated by the datapath.
module azc_sqrt #(
   parameter int W = 22
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [W-1:0]     radicand,
   output logic [W/2-1:0]   root,
   output logic             done
);

   logic [W-1:0] n_ff, n_in, res_ff, res_in, bit_ff, bit_in, trial;
   logic         busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = res_ff + bit_ff;
      if (start) begin
         n_in    = radicand;
         res_in  = '0;
         bit_in  = W'(1) << (W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in   = n_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign root = res_ff[W/2-1:0];
   assign done = done_ff;

endmodule

// File: hdl/azc_div.sv
// Constant divider by reciprocal multiplication, one registered product per request.
// Depends on nothing; instantiated by the datapath.
module azc_div #(
   parameter int DW    = 16,
   parameter int DIV_A = 10,
   parameter int DIV_B = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic          use_b,
   output logic [DW-1:0] quotient,
   output logic          done
);

   // Rounded-up reciprocals; the extra shift of the divisor's bit count keeps
   // the quotient exact for every dividend below 2**DW.
   localparam int     SHA  = DW + $clog2(DIV_A);
   localparam int     SHB  = DW + $clog2(DIV_B);
   localparam longint MULA = ((longint'(1) << SHA) + DIV_A - 1) / DIV_A;
   localparam longint MULB = ((longint'(1) << SHB) + DIV_B - 1) / DIV_B;
   localparam int     MW   = DW + 1;
   localparam int     PW   = DW + MW;

   logic [MW-1:0] mul_c;
   logic [PW-1:0] prod_ff;
   logic          use_b_ff, done_ff;

   assign mul_c = use_b ? MW'(MULB) : MW'(MULA);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
      if (start) begin
         prod_ff  <= PW'(dividend) * PW'(mul_c);
         use_b_ff <= use_b;
      end
   end

   assign quotient = use_b_ff ? DW'(prod_ff >> SHB) : DW'(prod_ff >> SHA);
   assign done     = done_ff;

endmodule

// File: hdl/azc_dp.sv
// Datapath: configuration, calibration state, squarer, root and divider units, result register.
// Depends on azc_pkg, azc_sqrt and azc_div; driven by commands from azc_ctrl.
module azc_dp
   import azc_pkg::*;
#(
   parameter int CAL_SAMPLES = 10,
   parameter int Z_LIMIT     = 2048
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output sts_type       sts,
   input  logic [47:0]   req_tdata,
   input  logic          csr_valid,
   input  logic [1:0]    csr_index,
   input  logic [11:0]   csr_data,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata,
   output logic [1:0]    rsp_tuser
);

   localparam int CntW = $clog2(CAL_SAMPLES + 1);

   logic [1:0]               fs_ff;
   logic signed [RawW-1:0]   xoff_ff, yoff_ff;
   logic signed [RawW-1:0]   x_ff, y_ff, z_ff;
   logic signed [OutW-1:0]   prev_x_ff, prev_y_ff;
   logic signed [RawW-1:0]   prev_z_ff;
   logic [RootW-1:0]         held_ff;
   logic signed [RawW-1:0]   zoff_ff;
   logic signed [SumW-1:0]   sum_ff;
   logic [CntW-1:0]          cnt_ff;
   logic                     done_cal_ff;
   logic signed [25:0]       prod_ff;
   logic signed [26:0]       acc_ff;
   logic signed [OutW-1:0]   xo_ff, yo_ff, zo_ff;
   logic                     rebuilt_ff, div_neg_ff;
   logic                     rsp_valid_ff;
   logic [39:0]              rsp_data_ff;
   logic [1:0]               rsp_user_ff;

   logic [RootW-1:0]         r;
   logic [RootW:0]           two_r;
   logic [13:0]              absx, absy, absz, adx, ady, adz;
   logic signed [OutW-1:0]   sq_op, xo_c, yo_c, zo_c;
   logic signed [14:0]       num_x, num_y;
   logic [DivW-1:0]          div_dividend, div_q;
   logic                     div_neg_c, div_done, root_done;
   logic signed [DivW:0]     q_signed;
   logic [RootW-1:0]         root;
   logic signed [SumW-1:0]   rec;

   assign r     = one_g(fs_ff);
   assign two_r = {r, 1'b0};
   assign absx  = abs14(14'(x_ff));
   assign absy  = abs14(14'(y_ff));
   assign absz  = abs14(14'(z_ff));
   assign adx   = abs14(14'(x_ff) - 14'(prev_x_ff));
   assign ady   = abs14(14'(y_ff) - 14'(prev_y_ff));
   assign adz   = abs14(14'(z_ff) - 14'(prev_z_ff));

   assign xo_c = OutW'(x_ff) + OutW'(xoff_ff);
   assign yo_c = OutW'(y_ff) + OutW'(yoff_ff);
   assign zo_c = OutW'(z_ff) + OutW'(zoff_ff);

   // Level and stable test against the current one-g magnitude.
   assign sts.pass = (absx < 14'(r >> 1)) && (absy < 14'(r >> 1)) &&
                     (z_ff > $signed(14'(r >> 3))) && (14'(z_ff) < $signed(14'(two_r))) &&
                     (adx < 14'(r >> 3)) && (ady < 14'(r >> 3)) && (adz < 14'(r >> 3));

   assign sts.cal_done  = done_cal_ff;
   assign sts.rebuilt   = absz > 14'(Z_LIMIT);
   assign sts.cal_full  = (cnt_ff + 1'b1) == CntW'(CAL_SAMPLES);
   assign sts.rad_pos   = acc_ff > 0;
   assign sts.root_done = root_done;
   assign sts.div_done  = div_done;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign sq_op = cmd.use_smooth ? (cmd.sq0 ? prev_x_ff : prev_y_ff)
                                 : (cmd.sq0 ? OutW'(x_ff) : OutW'(y_ff));

   assign num_x = 15'(xo_ff) + 15'(prev_x_ff) + 15'(prev_x_ff);
   assign num_y = 15'(yo_ff) + 15'(prev_y_ff) + 15'(prev_y_ff);

   always_comb begin
      case (cmd.div_sel)
         DIV_MEAN: begin
            div_neg_c    = sum_ff[SumW-1];
            div_dividend = sum_ff[SumW-1] ? DivW'(-sum_ff) : DivW'(sum_ff);
         end
         DIV_SMX: begin
            div_neg_c    = num_x[14];
            div_dividend = num_x[14] ? DivW'(-num_x) : DivW'(num_x);
         end
         default: begin
            div_neg_c    = num_y[14];
            div_dividend = num_y[14] ? DivW'(-num_y) : DivW'(num_y);
         end
      endcase
   end

   assign q_signed = div_neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
   assign rec      = SumW'(root) - SumW'(z_ff);

   azc_sqrt #(.W(SqrtW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_go),
      .radicand (SqrtW'(acc_ff[20:0])),
      .root     (root),
      .done     (root_done)
   );

   // The mean divides by the sample count, the smoothing steps by three.
   azc_div #(.DW(DivW), .DIV_A(CAL_SAMPLES), .DIV_B(3)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (div_dividend),
      .use_b    (cmd.div_sel != DIV_MEAN),
      .quotient (div_q),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff        <= '0;
         xoff_ff      <= '0;
         yoff_ff      <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_z_ff    <= '0;
         held_ff      <= '0;
         zoff_ff      <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         done_cal_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FULL_SCALE: fs_ff   <= csr_data[1:0];
               CSR_X_OFFSET:   xoff_ff <= csr_data;
               CSR_Y_OFFSET:   yoff_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.cal_fail) begin
            cnt_ff    <= '0;
            sum_ff    <= '0;
            prev_x_ff <= OutW'(x_ff);
            prev_y_ff <= OutW'(y_ff);
            prev_z_ff <= z_ff;
         end
         if (cmd.accum) begin
            cnt_ff    <= cnt_ff + 1'b1;
            sum_ff    <= sum_ff + rec;
            prev_x_ff <= OutW'(x_ff);
            prev_y_ff <= OutW'(y_ff);
            prev_z_ff <= z_ff;
         end
         if (cmd.apply && sts.rebuilt && prev_x_ff == '0 && prev_y_ff == '0) begin
            prev_x_ff <= xo_c;
            prev_y_ff <= yo_c;
         end
         if (cmd.div_take) begin
            case (cmd.div_sel)
               DIV_MEAN: begin
                  zoff_ff     <= RawW'(q_signed);
                  done_cal_ff <= 1'b1;
               end
               DIV_SMX: prev_x_ff <= OutW'(q_signed);
               default: prev_y_ff <= OutW'(q_signed);
            endcase
         end
         if (cmd.held_take)
            held_ff <= root;
         if (cmd.out_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         x_ff <= req_tdata[15:4];
         y_ff <= req_tdata[31:20];
         z_ff <= req_tdata[47:36];
      end
      if (cmd.sq0) begin
         prod_ff <= sq_op * sq_op;
         acc_ff  <= 27'(one_g_sq(fs_ff));
      end
      if (cmd.sq1) begin
         prod_ff <= sq_op * sq_op;
         acc_ff  <= acc_ff - 27'(prod_ff);
      end
      if (cmd.sq2)
         acc_ff <= acc_ff - 27'(prod_ff);
      if (cmd.div_go)
         div_neg_ff <= div_neg_c;
      if (cmd.apply) begin
         xo_ff      <= xo_c;
         yo_ff      <= yo_c;
         zo_ff      <= zo_c;
         rebuilt_ff <= sts.rebuilt;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {1'b0, (rebuilt_ff ? OutW'(held_ff) : zo_ff), yo_ff, xo_ff};
         rsp_user_ff <= {done_cal_ff, rebuilt_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: hdl/azc_ctrl.sv
// Controller: sequences calibration, offset application and z rebuild for one request.
// Depends on azc_pkg; drives azc_dp through the command struct.
module azc_ctrl
   import azc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_SQ0, ST_SQ1, ST_SQ2, ST_RAD, ST_ROOT_GO, ST_ROOT_WAIT,
      ST_ACCUM, ST_DIV_GO, ST_DIV_WAIT, ST_DIV_TAKE, ST_APPLY, ST_HELD, ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic        smooth_ff, smooth_in;
   div_sel_type sel_ff, sel_in;

   always_comb begin
      state_in  = state_ff;
      smooth_in = smooth_ff;
      sel_in    = sel_ff;
      cmd            = '0;
      cmd.use_smooth = smooth_ff;
      cmd.div_sel    = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid)
               state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.cal_done) begin
               state_in = ST_APPLY;
            end else if (sts.pass) begin
               smooth_in = 1'b0;
               state_in  = ST_SQ0;
            end else begin
               cmd.cal_fail = 1'b1;
               state_in     = ST_APPLY;
            end
         end
         ST_SQ0: begin
            cmd.sq0  = 1'b1;
            state_in = ST_SQ1;
         end
         ST_SQ1: begin
            cmd.sq1  = 1'b1;
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            cmd.sq2  = 1'b1;
            state_in = ST_RAD;
         end
         ST_RAD: begin
            // A rebuilt z keeps the held value when the radicand is not positive.
            state_in = (!smooth_ff || sts.rad_pos) ? ST_ROOT_GO : ST_OUT;
         end
         ST_ROOT_GO: begin
            cmd.root_go = 1'b1;
            state_in    = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (sts.root_done)
               state_in = smooth_ff ? ST_HELD : ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (sts.cal_full) begin
               sel_in   = DIV_MEAN;
               state_in = ST_DIV_GO;
            end else begin
               state_in = ST_APPLY;
            end
         end
         ST_DIV_GO: begin
            cmd.div_go = 1'b1;
            state_in   = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done)
               state_in = ST_DIV_TAKE;
         end
         ST_DIV_TAKE: begin
            cmd.div_take = 1'b1;
            case (sel_ff)
               DIV_MEAN: state_in = ST_APPLY;
               DIV_SMX: begin
                  sel_in   = DIV_SMY;
                  state_in = ST_DIV_GO;
               end
               default: begin
                  smooth_in = 1'b1;
                  state_in  = ST_SQ0;
               end
            endcase
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            if (sts.rebuilt) begin
               sel_in   = DIV_SMX;
               state_in = ST_DIV_GO;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_HELD: begin
            cmd.held_take = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         smooth_ff <= 1'b0;
         sel_ff    <= DIV_MEAN;
      end else begin
         state_ff  <= state_in;
         smooth_ff <= smooth_in;
         sel_ff    <= sel_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;

endmodule

// File: hdl/azc_checker.sv
// Port-level checker for the accelerometer z block, bound to the top level.
// Depends on accel_z_calibrate_reconstruct_assert.svh for the assertion macros.
`include "accel_z_calibrate_reconstruct_assert.svh"

module azc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic [1:0] pend_ff, pend_in;
   logic       seen_cal_ff, seen_cal_in;

   // Requests in flight: one at work plus one waiting in the output register.
   always_comb begin
      pend_in = pend_ff + 2'(req_tvalid && req_tready) - 2'(rsp_tvalid && rsp_tready);
      seen_cal_in = seen_cal_ff || (rsp_tvalid && rsp_tready && rsp_tuser[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         seen_cal_ff <= 1'b0;
      end else begin
         pend_ff     <= pend_in;
         seen_cal_ff <= seen_cal_in;
      end
   end

   `AZC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `AZC_ASSERT_SAME(a_pend_bound, clock, reset, 1'b1, pend_ff != 2'd3)
   `AZC_ASSERT_SAME(a_rsp_has_req, clock, reset, rsp_tvalid, pend_ff != 2'd0)
   `AZC_ASSERT_SAME(a_cal_sticky, clock, reset, rsp_tvalid && seen_cal_ff, rsp_tuser[1])

endmodule

bind accel_z_calibrate_reconstruct azc_checker u_azc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/sv/accel_z_calibrate_reconstruct_test.sv
// Self-checking testbench for the accelerometer z calibration and rebuild block.
// Depends on azc_pkg for register codes; predicts every response from its own model.
module accel_z_calibrate_reconstruct_test;
   import azc_pkg::*;

   // One expected response, in the field order of the response stream.
   typedef struct {
      logic [12:0] x_out;
      logic [12:0] y_out;
      logic [12:0] z_out;
      logic        z_rebuilt;
      logic        is_calibrated;
   } accel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [11:0] csr_data = '0;

   accel_z_calibrate_reconstruct dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Predictor copy of the configuration registers.
   logic [1:0] scale_sel;
   int         x_trim;
   int         y_trim;

   // Predictor copy of the calibration and smoothing state.
   int  last_x, last_y, last_raw_z, good_z, z_trim, trim_sum, trim_count;
   bit  trim_done;

   accel_result_type pending_results[$];
   int  mismatches = 0;
   int  requests_sent = 0;
   int  responses_seen = 0;
   int  rebuilt_seen = 0;
   int  calibrated_seen = 0;

   // When quiet is set, neither side idles at random.
   bit  quiet = 1'b0;
   // A request for a long receiver hold-off; the receiver process counts it down.
   int  hold_request = 0;
   int  hold_left = 0;

   function automatic int one_g_counts(input logic [1:0] sel);
      case (sel)
         2'd0:    return 1024;
         2'd1:    return 512;
         2'd2:    return 256;
         default: return 128;
      endcase
   endfunction

   function automatic int floor_root(input int n);
      int r;
      r = 0;
      for (int b = 11; b >= 0; b--) begin
         if ((r | (1 << b)) * (r | (1 << b)) <= n) r = r | (1 << b);
      end
      return r;
   endfunction

   function automatic int magnitude(input int v);
      return v < 0 ? -v : v;
   endfunction

   // Works out the response to one accepted request and advances the state.
   function automatic accel_result_type predict_sample(input logic [47:0] words);
      accel_result_type res;
      logic signed [11:0] xs, ys, zs;
      int r, x, y, z, half, eighth, full, mag;
      bit rebuilt;
      r  = one_g_counts(scale_sel);
      xs = words[15:4];
      ys = words[31:20];
      zs = words[47:36];
      x  = xs;
      y  = ys;
      z  = zs;
      if (!trim_done) begin
         half   = r >> 1;
         eighth = r >> 3;
         if (magnitude(x) < half && magnitude(y) < half && z > eighth && z < 2 * r &&
             magnitude(x - last_x) < eighth && magnitude(y - last_y) < eighth &&
             magnitude(z - last_raw_z) < eighth) begin
            trim_sum   += floor_root(r * r - x * x - y * y) - z;
            trim_count += 1;
         end else begin
            trim_sum   = 0;
            trim_count = 0;
         end
         if (trim_count >= 10) begin
            z_trim    = trim_sum / 10;
            trim_done = 1'b1;
         end
         last_x     = x;
         last_y     = y;
         last_raw_z = z;
      end
      rebuilt = magnitude(z) > 2048;
      x += x_trim;
      y += y_trim;
      z += z_trim;
      if (rebuilt) begin
         // Smoothing seeds itself from the current sample when its history is empty.
         full = r * r;
         if (last_x == 0 && last_y == 0) begin
            last_x = x;
            last_y = y;
         end
         last_x = (x + 2 * last_x) / 3;
         last_y = (y + 2 * last_y) / 3;
         mag = last_x * last_x + last_y * last_y;
         if (mag < full) good_z = floor_root(full - mag);
         z = good_z;
      end
      res.x_out         = 13'(x);
      res.y_out         = 13'(y);
      res.z_out         = 13'(z);
      res.z_rebuilt     = rebuilt;
      res.is_calibrated = trim_done;
      return res;
   endfunction

   // Builds a raw word whose 12-bit sample is v, with random noise in the low nibble.
   function automatic logic [15:0] raw_word(input int v);
      logic [11:0] s;
      s = 12'(v);
      return {s, 4'($urandom_range(15))};
   endfunction

   // Offers one request and records its expected response once accepted.
   task automatic send_sample(input logic [47:0] words);
      if (!quiet && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tdata  <= words;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_sample(words));
      requests_sent++;
   endtask

   task automatic send_xyz(input int x, input int y, input int z);
      send_sample({raw_word(z), raw_word(y), raw_word(x)});
   endtask

   // A run of level, stable samples around a random tilt; runs of eleven or more calibrate.
   task automatic send_level_run(input int count);
      int r, bx, by, bz, j;
      r  = one_g_counts(scale_sel);
      j  = r / 16 - 1;
      bx = $urandom_range(0, r / 2) - r / 4;
      by = $urandom_range(0, r / 2) - r / 4;
      bz = $urandom_range(r / 2, r + r / 2);
      repeat (count) begin
         send_xyz(bx + $urandom_range(0, 2 * j) - j, by + $urandom_range(0, 2 * j) - j,
                  bz + $urandom_range(0, 2 * j) - j);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Register writes happen only with the block drained.
   task automatic write_register(input csr_index_type idx, input logic [11:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FULL_SCALE: scale_sel = value[1:0];
         CSR_X_OFFSET:   x_trim = int'(signed'(value));
         CSR_Y_OFFSET:   y_trim = int'(signed'(value));
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [1:0] sel, input int xo, input int yo);
      wait_drained();
      write_register(CSR_FULL_SCALE, 12'(sel));
      write_register(CSR_X_OFFSET, 12'(xo));
      write_register(CSR_Y_OFFSET, 12'(yo));
   endtask

   // Field extremes, the most negative and positive samples, and z at its limits.
   task automatic test_extremes();
      send_sample(48'h0000_0000_0000);
      send_sample(48'hFFFF_FFFF_FFFF);
      send_sample(48'h8000_8000_8000);
      send_sample(48'h7FFF_7FFF_7FFF);
      send_sample(48'h8000_7FFF_0000);
      send_sample(48'h7FFF_8000_FFFF);
      send_xyz(0, 0, -2048);
      send_xyz(2047, -2048, 2047);
      send_xyz(-2048, 2047, 1);
      // A short stable run that is broken before it can calibrate.
      send_level_run(6);
      send_xyz(2000, 0, 0);
   endtask

   // Each full-scale setting with extreme and zero offsets, calibration kept broken.
   task automatic test_scale_settings();
      int xo[3] = '{-2048, 2047, 0};
      for (int s = 0; s < 4; s++) begin
         set_config(2'(s), xo[s % 3], xo[(s + 1) % 3]);
         repeat (12) begin
            send_level_run($urandom_range(2, 8));
            send_sample({16'($urandom), 16'($urandom), 16'($urandom)});
         end
      end
   endtask

   // A short run broken by an outlier, then a clean run of level samples that completes calibration.
   task automatic test_calibration();
      set_config(2'($urandom_range(3)), $urandom_range(0, 200) - 100,
                 $urandom_range(0, 200) - 100);
      send_level_run(4);
      send_xyz(1500, -1500, 0);
      send_level_run(14);
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      quiet = 1'b1;
      hold_request = 300;
      repeat (40) send_sample({16'($urandom), 16'($urandom), 16'($urandom)});
      quiet = 1'b0;
   endtask

   // Mostly well-formed level runs with random content, mixed with noise.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         set_config(2'($urandom_range(3)), $urandom_range(0, 4095) - 2048,
                    $urandom_range(0, 4095) - 2048);
         quiet = (phase == 2);
         for (int n = 0; n < 270; ) begin
            if ($urandom_range(99) < 60) begin
               send_level_run(12);
               n += 12;
            end else begin
               send_sample({16'($urandom), 16'($urandom), 16'($urandom)});
               n += 1;
            end
         end
      end
      quiet = 1'b0;
   endtask

   // Receiver readiness: random idling, a quiet stretch, and counted hold-offs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 30);
      end
   end

   // Response checker: each accepted response against the oldest expectation.
   always @(posedge clock) begin
      accel_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (rsp_tuser[0]) rebuilt_seen++;
         if (rsp_tuser[1]) calibrated_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response tdata=%h tuser=%b", $time, rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tdata[12:0] !== exp_r.x_out) begin
               $display("%0t: x_out expected %h actual %h", $time, exp_r.x_out, rsp_tdata[12:0]);
               mismatches++;
            end
            if (rsp_tdata[25:13] !== exp_r.y_out) begin
               $display("%0t: y_out expected %h actual %h", $time, exp_r.y_out,
                        rsp_tdata[25:13]);
               mismatches++;
            end
            if (rsp_tdata[38:26] !== exp_r.z_out) begin
               $display("%0t: z_out expected %h actual %h", $time, exp_r.z_out,
                        rsp_tdata[38:26]);
               mismatches++;
            end
            if (rsp_tuser[0] !== exp_r.z_rebuilt) begin
               $display("%0t: z_rebuilt expected %b actual %b", $time, exp_r.z_rebuilt,
                        rsp_tuser[0]);
               mismatches++;
            end
            if (rsp_tuser[1] !== exp_r.is_calibrated) begin
               $display("%0t: is_calibrated expected %b actual %b", $time,
                        exp_r.is_calibrated, rsp_tuser[1]);
               mismatches++;
            end
         end
      end
   end

   initial begin
      scale_sel = 2'd0;
      x_trim = 0;  y_trim = 0;
      last_x = 0;  last_y = 0;  last_raw_z = 0;  good_z = 0;
      z_trim = 0;  trim_sum = 0;  trim_count = 0;  trim_done = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_scale_settings();
      test_calibration();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      repeat (100) @(posedge clock);

      $display("Covered %0d requests and %0d responses across all full-scale settings,",
               requests_sent, responses_seen);
      $display("offset extremes, calibration (%0d calibrated, %0d rebuilt) and a long stall.",
               calibrated_seen, rebuilt_seen);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("accel_z_calibrate_reconstruct_test: PASS");
      end else begin
         $display("accel_z_calibrate_reconstruct_test: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #30000000;
      $display("accel_z_calibrate_reconstruct_test: FAIL");
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/azc_pkg.sv
hdl/azc_sqrt.sv
hdl/azc_div.sv
hdl/azc_dp.sv
hdl/azc_ctrl.sv
hdl/accel_z_calibrate_reconstruct.sv
hdl/azc_checker.sv
tb/sv/accel_z_calibrate_reconstruct_test.sv
